### rtl/core/source_tokenizer_macros.svh
// assertion macros for the source tokenizer
`ifndef SOURCE_TOKENIZER_MACROS_SVH
`define SOURCE_TOKENIZER_MACROS_SVH
`ifndef SYNTHESIS
`define ST_ASSERT_IMP(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");
`define ST_ASSERT_NXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");
`else
`define ST_ASSERT_IMP(label, clk, rst_n, a, b)
`define ST_ASSERT_NXT(label, clk, rst_n, a, b)
`endif
`endif

### rtl/core/stok_pkg.sv
// types, constants and helper functions shared by the tokenizer modules
package stok_pkg;
	localparam int POS_BITS = 16;
	localparam int KEYWORD_MAX = 8;
	localparam int WLEN_BITS = $clog2(KEYWORD_MAX + 2);

	localparam logic [1:0] REC_TEXT = 2'd0;
	localparam logic [1:0] REC_TOKEN = 2'd1;
	localparam logic [1:0] REC_ERROR = 2'd2;

	localparam logic [2:0] ERR_COMMENT = 3'd0;
	localparam logic [2:0] ERR_STRING = 3'd1;
	localparam logic [2:0] ERR_CHAR = 3'd2;
	localparam logic [2:0] ERR_AMP = 3'd3;
	localparam logic [2:0] ERR_BAR = 3'd4;

	localparam logic [5:0] K_INT = 6'd0;
	localparam logic [5:0] K_DOUBLE = 6'd1;
	localparam logic [5:0] K_STR = 6'd2;
	localparam logic [5:0] K_IDENT = 6'd3;
	localparam logic [5:0] K_KW0 = 6'd4;
	localparam logic [5:0] K_LPAR = 6'd20;
	localparam logic [5:0] K_RPAR = 6'd21;
	localparam logic [5:0] K_LBRACE = 6'd22;
	localparam logic [5:0] K_RBRACE = 6'd23;
	localparam logic [5:0] K_SEMI = 6'd24;
	localparam logic [5:0] K_COMMA = 6'd25;
	localparam logic [5:0] K_ASSIGN = 6'd26;
	localparam logic [5:0] K_PLUS = 6'd27;
	localparam logic [5:0] K_MINUS = 6'd28;
	localparam logic [5:0] K_STAR = 6'd29;
	localparam logic [5:0] K_SLASH = 6'd30;
	localparam logic [5:0] K_PCT = 6'd31;
	localparam logic [5:0] K_EQ = 6'd32;
	localparam logic [5:0] K_NE = 6'd33;
	localparam logic [5:0] K_LT = 6'd34;
	localparam logic [5:0] K_LE = 6'd35;
	localparam logic [5:0] K_GT = 6'd36;
	localparam logic [5:0] K_GE = 6'd37;
	localparam logic [5:0] K_AND = 6'd38;
	localparam logic [5:0] K_OR = 6'd39;
	localparam logic [5:0] K_NOT = 6'd40;
	localparam logic [5:0] K_EOF = 6'd41;

	typedef enum logic [11:0] {
		M_IDLE      = 12'b000000000001,
		M_IDENT     = 12'b000000000010,
		M_INT       = 12'b000000000100,
		M_INTDOT    = 12'b000000001000,
		M_FRAC      = 12'b000000010000,
		M_STR       = 12'b000000100000,
		M_ESC       = 12'b000001000000,
		M_OP        = 12'b000010000000,
		M_LINECMT   = 12'b000100000000,
		M_BLOCK     = 12'b001000000000,
		M_BLOCKSTAR = 12'b010000000000,
		M_HALT      = 12'b100000000000
	} mode_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       end_of_source;
	} in_beat_t;

	typedef struct packed {
		logic [1:0]  record;
		logic [5:0]  kind;
		logic [7:0]  text_byte;
		logic [15:0] line_no;
		logic [15:0] col_no;
		logic [2:0]  error_code;
		logic        last_of_run;
	} out_beat_t;

	// up to three results per input beat
	typedef struct packed {
		logic [1:0]      cnt;
		out_beat_t [2:0] res;
	} res_group_t;

	typedef logic [POS_BITS-1:0] pos_t;

	function automatic logic [15:0] clamp16(input pos_t v);
		logic [15:0] r;
		if (POS_BITS > 16 && (v >> 16) != '0) r = 16'hFFFF;
		else r = 16'(v);
		return r;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
	endfunction

	function automatic logic is_word(input logic [7:0] c);
		return is_alpha(c) || is_digit(c) || c == 8'h5F;
	endfunction

	// keyword text packed first byte in the low lane, zero padded
	function automatic logic [63:0] kw_text(input logic [3:0] i);
		logic [63:0] r;
		unique case (i)
			4'd0: r = {24'h0, "ssalc"};
			4'd1: r = {16'h0, "citats"};
			4'd2: r = {32'h0, "diov"};
			4'd3: r = {40'h0, "tni"};
			4'd4: r = {16'h0, "elbuod"};
			4'd5: r = {8'h0, "naeloob"};
			4'd6: r = {16'h0, "gnirtS"};
			4'd7: r = {48'h0, "fi"};
			4'd8: r = {32'h0, "esle"};
			4'd9: r = {24'h0, "elihw"};
			4'd10: r = {40'h0, "rof"};
			4'd11: r = {16'h0, "nruter"};
			4'd12: r = {32'h0, "eurt"};
			4'd13: r = {24'h0, "eslaf"};
			4'd14: r = {24'h0, "tnirp"};
			default: r = {32'h0, "llun"};
		endcase
		return r;
	endfunction

	function automatic logic [3:0] kw_len(input logic [3:0] i);
		logic [3:0] r;
		unique case (i)
			4'd0: r = 4'd5;
			4'd1: r = 4'd6;
			4'd2: r = 4'd4;
			4'd3: r = 4'd3;
			4'd4: r = 4'd6;
			4'd5: r = 4'd7;
			4'd6: r = 4'd6;
			4'd7: r = 4'd2;
			4'd8: r = 4'd4;
			4'd9: r = 4'd5;
			4'd10: r = 4'd3;
			4'd11: r = 4'd6;
			4'd12: r = 4'd4;
			4'd13: r = 4'd5;
			4'd14: r = 4'd5;
			default: r = 4'd4;
		endcase
		return r;
	endfunction
endpackage

### rtl/core/stok_kw_match.sv
// keyword lookup over the identifier buffer
module stok_kw_match (
	input  logic [stok_pkg::KEYWORD_MAX-1:0][7:0]  word_buf,
	input  logic [stok_pkg::WLEN_BITS-1:0]         word_len,
	output logic [5:0]                             kind
);
	import stok_pkg::*;

	logic [63:0] buf64;

	// widen or trim the buffer to eight bytes, the width of a keyword table entry
	always_comb begin
		buf64 = '0;
		for (int i = 0; i < 8; i++) begin
			if (i < KEYWORD_MAX) buf64[i*8 +: 8] = word_buf[i];
		end
	end

	// sixteen independent compares, the lowest matching index wins
	always_comb begin
		kind = K_IDENT;
		for (int k = 15; k >= 0; k--) begin
			if (word_len <= WLEN_BITS'(KEYWORD_MAX)
				&& word_len == WLEN_BITS'(kw_len(4'(k)))
				&& buf64 == kw_text(4'(k)))
				kind = K_KW0 + 6'(k);
		end
	end
endmodule

### rtl/core/stok_scan.sv
// scanner next-state and result logic for one registered source beat
module stok_scan (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  step,
	input  stok_pkg::in_beat_t                    beat,
	output stok_pkg::res_group_t                  grp
);
	import stok_pkg::*;

	localparam pos_t MAXPOS = '1;

	mode_t mode_q, mode_d;
	logic [7:0] pend_q, pend_d;
	pos_t line_q, col_q, sl_q, sc_q, line_d, col_d, sl_d, sc_d;
	logic [KEYWORD_MAX-1:0][7:0] wbuf_q, wbuf_d;
	logic [WLEN_BITS-1:0] wlen_q, wlen_d;
	logic [5:0] word_kind;

	stok_kw_match u_kw (.word_buf(wbuf_q), .word_len(wlen_q), .kind(word_kind));

	logic [7:0] c;
	pos_t al, ac;
	res_group_t g;

	function automatic out_beat_t mk(input logic [1:0] r, input logic [5:0] k,
		input logic [7:0] tb, input pos_t ln, input pos_t cl, input logic [2:0] e);
		out_beat_t o;
		o.record = r;
		o.kind = k;
		o.text_byte = tb;
		o.line_no = clamp16(ln);
		o.col_no = clamp16(cl);
		o.error_code = e;
		o.last_of_run = 1'b0;
		return o;
	endfunction

	// combinational step of the scanner
	always_comb begin
		logic do_idle;
		logic [5:0] k;
		logic single;
		mode_d = mode_q;
		pend_d = pend_q;
		line_d = line_q;
		col_d = col_q;
		sl_d = sl_q;
		sc_d = sc_q;
		wbuf_d = wbuf_q;
		wlen_d = wlen_q;
		g = '0;
		do_idle = 1'b0;
		k = K_LPAR;
		single = 1'b0;
		c = beat.ch;
		al = line_q;
		ac = col_q;
		if (c == 8'h0A) begin
			if (al < MAXPOS) al = al + 1'b1;
			ac = pos_t'(1);
		end else if (ac < MAXPOS) begin
			ac = ac + 1'b1;
		end

		if (beat.end_of_source) begin
			// flush pending token and close with eof, or report an unterminated construct
			if (mode_q != M_HALT) begin
				logic fin;
				fin = 1'b1;
				unique case (mode_q)
					M_IDENT: begin
						g.res[0] = mk(REC_TOKEN, word_kind, 8'h0, sl_q, sc_q, ERR_COMMENT);
						g.cnt = 2'd1;
					end
					M_INT: begin
						g.res[0] = mk(REC_TOKEN, K_INT, 8'h0, sl_q, sc_q, ERR_COMMENT);
						g.cnt = 2'd1;
					end
					M_FRAC: begin
						g.res[0] = mk(REC_TOKEN, K_DOUBLE, 8'h0, sl_q, sc_q, ERR_COMMENT);
						g.cnt = 2'd1;
					end
					M_INTDOT: begin
						g.res[0] = mk(REC_TOKEN, K_INT, 8'h0, sl_q, sc_q, ERR_COMMENT);
						g.res[1] = mk(REC_ERROR, 6'd0, 8'h0, line_q, col_q, ERR_CHAR);
						g.cnt = 2'd2;
						fin = 1'b0;
					end
					M_STR, M_ESC: begin
						g.res[0] = mk(REC_ERROR, 6'd0, 8'h0, line_q, col_q, ERR_STRING);
						g.cnt = 2'd1;
						fin = 1'b0;
					end
					M_BLOCK, M_BLOCKSTAR: begin
						g.res[0] = mk(REC_ERROR, 6'd0, 8'h0, line_q, col_q, ERR_COMMENT);
						g.cnt = 2'd1;
						fin = 1'b0;
					end
					M_OP: begin
						if (pend_q == 8'h26) begin
							g.res[0] = mk(REC_ERROR, 6'd0, 8'h0, line_q, col_q, ERR_AMP);
							fin = 1'b0;
						end else if (pend_q == 8'h7C) begin
							g.res[0] = mk(REC_ERROR, 6'd0, 8'h0, line_q, col_q, ERR_BAR);
							fin = 1'b0;
						end else begin
							priority case (pend_q)
								8'h2F: k = K_SLASH;
								8'h3D: k = K_ASSIGN;
								8'h21: k = K_NOT;
								8'h3C: k = K_LT;
								default: k = K_GT;
							endcase
							g.res[0] = mk(REC_TOKEN, k, 8'h0, sl_q, sc_q, ERR_COMMENT);
						end
						g.cnt = 2'd1;
					end
					default: g.cnt = 2'd0;
				endcase
				if (fin) begin
					g.res[g.cnt] = mk(REC_TOKEN, K_EOF, 8'h0, line_q, col_q, ERR_COMMENT);
					g.cnt = g.cnt + 2'd1;
				end
			end
			mode_d = M_IDLE;
			pend_d = '0;
			line_d = pos_t'(1);
			col_d = pos_t'(1);
			sl_d = pos_t'(1);
			sc_d = pos_t'(1);
			wbuf_d = '0;
			wlen_d = '0;
		end else if (mode_q != M_HALT) begin
			line_d = al;
			col_d = ac;
			unique case (mode_q)
				M_IDENT: begin
					if (is_word(c)) begin
						g.res[0] = mk(REC_TEXT, 6'd0, c, '0, '0, ERR_COMMENT);
						g.cnt = 2'd1;
					end else begin
						g.res[0] = mk(REC_TOKEN, word_kind, 8'h0, sl_q, sc_q, ERR_COMMENT);
						g.cnt = 2'd1;
						do_idle = 1'b1;
					end
				end
				M_INT: begin
					if (is_digit(c)) begin
						g.res[0] = mk(REC_TEXT, 6'd0, c, '0, '0, ERR_COMMENT);
						g.cnt = 2'd1;
					end else if (c == 8'h2E) begin
						mode_d = M_INTDOT;
					end else begin
						g.res[0] = mk(REC_TOKEN, K_INT, 8'h0, sl_q, sc_q, ERR_COMMENT);
						g.cnt = 2'd1;
						do_idle = 1'b1;
					end
				end
				M_INTDOT: begin
					if (is_digit(c)) begin
						g.res[0] = mk(REC_TEXT, 6'd0, 8'h2E, '0, '0, ERR_COMMENT);
						g.res[1] = mk(REC_TEXT, 6'd0, c, '0, '0, ERR_COMMENT);
						g.cnt = 2'd2;
						mode_d = M_FRAC;
					end else begin
						g.res[0] = mk(REC_TOKEN, K_INT, 8'h0, sl_q, sc_q, ERR_COMMENT);
						g.res[1] = mk(REC_ERROR, 6'd0, 8'h0, line_q, col_q, ERR_CHAR);
						g.cnt = 2'd2;
						mode_d = M_HALT;
					end
				end
				M_FRAC: begin
					if (is_digit(c)) begin
						g.res[0] = mk(REC_TEXT, 6'd0, c, '0, '0, ERR_COMMENT);
						g.cnt = 2'd1;
					end else begin
						g.res[0] = mk(REC_TOKEN, K_DOUBLE, 8'h0, sl_q, sc_q, ERR_COMMENT);
						g.cnt = 2'd1;
						do_idle = 1'b1;
					end
				end
				M_STR: begin
					if (c == 8'h22) begin
						g.res[0] = mk(REC_TOKEN, K_STR, 8'h0, sl_q, sc_q, ERR_COMMENT);
						g.cnt = 2'd1;
						mode_d = M_IDLE;
					end else if (c == 8'h5C) begin
						mode_d = M_ESC;
					end else begin
						g.res[0] = mk(REC_TEXT, 6'd0, c, '0, '0, ERR_COMMENT);
						g.cnt = 2'd1;
					end
				end
				M_ESC: begin
					logic [7:0] e;
					priority case (c)
						8'h6E: e = 8'h0A;
						8'h74: e = 8'h09;
						8'h72: e = 8'h0D;
						default: e = c;
					endcase
					g.res[0] = mk(REC_TEXT, 6'd0, e, '0, '0, ERR_COMMENT);
					g.cnt = 2'd1;
					mode_d = M_STR;
				end
				M_OP: begin
					mode_d = M_IDLE;
					if (pend_q == 8'h26) begin
						if (c == 8'h26)
							g.res[0] = mk(REC_TOKEN, K_AND, 8'h0, sl_q, sc_q, ERR_COMMENT);
						else begin
							g.res[0] = mk(REC_ERROR, 6'd0, 8'h0, line_q, col_q, ERR_AMP);
							mode_d = M_HALT;
						end
						g.cnt = 2'd1;
					end else if (pend_q == 8'h7C) begin
						if (c == 8'h7C)
							g.res[0] = mk(REC_TOKEN, K_OR, 8'h0, sl_q, sc_q, ERR_COMMENT);
						else begin
							g.res[0] = mk(REC_ERROR, 6'd0, 8'h0, line_q, col_q, ERR_BAR);
							mode_d = M_HALT;
						end
						g.cnt = 2'd1;
					end else if (pend_q == 8'h2F) begin
						if (c == 8'h2F) mode_d = M_LINECMT;
						else if (c == 8'h2A) mode_d = M_BLOCK;
						else begin
							g.res[0] = mk(REC_TOKEN, K_SLASH, 8'h0, sl_q, sc_q, ERR_COMMENT);
							g.cnt = 2'd1;
							do_idle = 1'b1;
						end
					end else if (c == 8'h3D) begin
						priority case (pend_q)
							8'h3D: k = K_EQ;
							8'h21: k = K_NE;
							8'h3C: k = K_LE;
							default: k = K_GE;
						endcase
						g.res[0] = mk(REC_TOKEN, k, 8'h0, sl_q, sc_q, ERR_COMMENT);
						g.cnt = 2'd1;
					end else begin
						priority case (pend_q)
							8'h3D: k = K_ASSIGN;
							8'h21: k = K_NOT;
							8'h3C: k = K_LT;
							default: k = K_GT;
						endcase
						g.res[0] = mk(REC_TOKEN, k, 8'h0, sl_q, sc_q, ERR_COMMENT);
						g.cnt = 2'd1;
						do_idle = 1'b1;
					end
				end
				M_LINECMT: if (c == 8'h0A) mode_d = M_IDLE;
				M_BLOCK: if (c == 8'h2A) mode_d = M_BLOCKSTAR;
				M_BLOCKSTAR: begin
					if (c == 8'h2F) mode_d = M_IDLE;
					else if (c != 8'h2A) mode_d = M_BLOCK;
				end
				default: do_idle = 1'b1;
			endcase

			// start of a new token, from idle or after a token ends; whitespace is skipped
			if (do_idle) begin
				mode_d = M_IDLE;
				if (c == 8'h20 || c == 8'h09 || c == 8'h0D || c == 8'h0A) begin
				end else if (is_digit(c)) begin
					sl_d = line_q;
					sc_d = col_q;
					g.res[g.cnt] = mk(REC_TEXT, 6'd0, c, '0, '0, ERR_COMMENT);
					g.cnt = g.cnt + 2'd1;
					mode_d = M_INT;
				end else if (c == 8'h22) begin
					sl_d = line_q;
					sc_d = col_q;
					mode_d = M_STR;
				end else if (is_alpha(c) || c == 8'h5F) begin
					sl_d = line_q;
					sc_d = col_q;
					wbuf_d = '0;
					wbuf_d[0] = c;
					wlen_d = WLEN_BITS'(1);
					g.res[g.cnt] = mk(REC_TEXT, 6'd0, c, '0, '0, ERR_COMMENT);
					g.cnt = g.cnt + 2'd1;
					mode_d = M_IDENT;
				end else if (c == 8'h2F || c == 8'h3D || c == 8'h21 || c == 8'h3C
					|| c == 8'h3E || c == 8'h26 || c == 8'h7C) begin
					sl_d = line_q;
					sc_d = col_q;
					pend_d = c;
					mode_d = M_OP;
				end else begin
					single = 1'b1;
					priority case (c)
						8'h28: k = K_LPAR;
						8'h29: k = K_RPAR;
						8'h7B: k = K_LBRACE;
						8'h7D: k = K_RBRACE;
						8'h3B: k = K_SEMI;
						8'h2C: k = K_COMMA;
						8'h2B: k = K_PLUS;
						8'h2D: k = K_MINUS;
						8'h2A: k = K_STAR;
						8'h25: k = K_PCT;
						default: single = 1'b0;
					endcase
					if (single) begin
						sl_d = line_q;
						sc_d = col_q;
						g.res[g.cnt] = mk(REC_TOKEN, k, 8'h0, line_q, col_q, ERR_COMMENT);
					end else begin
						g.res[g.cnt] = mk(REC_ERROR, 6'd0, 8'h0, al, ac, ERR_CHAR);
						mode_d = M_HALT;
					end
					g.cnt = g.cnt + 2'd1;
				end
			end else if (mode_q == M_IDENT && is_word(c)) begin
				if (wlen_q < WLEN_BITS'(KEYWORD_MAX)) wbuf_d[wlen_q[$clog2(KEYWORD_MAX)-1:0]] = c;
				if (wlen_q <= WLEN_BITS'(KEYWORD_MAX)) wlen_d = wlen_q + 1'b1;
			end
		end
		if (g.cnt != 2'd0) g.res[g.cnt - 2'd1].last_of_run = 1'b1;
	end

	assign grp = g;

	// scanner state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			pend_q <= '0;
			line_q <= pos_t'(1);
			col_q <= pos_t'(1);
			sl_q <= pos_t'(1);
			sc_q <= pos_t'(1);
			wbuf_q <= '0;
			wlen_q <= '0;
		end else if (step) begin
			mode_q <= mode_d;
			pend_q <= pend_d;
			line_q <= line_d;
			col_q <= col_d;
			sl_q <= sl_d;
			sc_q <= sc_d;
			wbuf_q <= wbuf_d;
			wlen_q <= wlen_d;
		end
	end
endmodule

### rtl/core/stok_out_buf.sv
// result register holding up to three results and unloading one per beat
module stok_out_buf (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  stok_pkg::res_group_t  grp,
	output logic                  empty_next,
	output logic                  out_valid,
	output stok_pkg::out_beat_t   out_data,
	input  logic                  out_ready
);
	import stok_pkg::*;

	out_beat_t [2:0] res_q;
	logic [1:0] cnt_q, idx_q;
	logic last_pop;

	assign out_valid = cnt_q != 2'd0;
	assign out_data = res_q[idx_q];
	assign last_pop = out_valid && out_ready && (idx_q + 2'd1 == cnt_q);
	// free now, or freeing with this beat
	assign empty_next = !out_valid || last_pop;

	// load a group or advance the read pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
		end else if (load) begin
			cnt_q <= grp.cnt;
			idx_q <= '0;
		end else if (last_pop) begin
			cnt_q <= '0;
			idx_q <= '0;
		end else if (out_valid && out_ready) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) res_q <= grp.res;
	end
endmodule

### rtl/core/source_tokenizer.sv
// source tokenizer top level
// Takes one source byte per beat and returns text, token and error beats.
// A byte is accepted in every cycle while its results (at most three) fit:
// the input stage holds one byte, the scanner decides all of its results in
// one pass, and the result register sends them one per cycle while out_ready is
// high. A byte with one or no result then sustains one byte per cycle; a byte
// with more results holds the input until its last result is taken.
`include "source_tokenizer_macros.svh"
module source_tokenizer (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  stok_pkg::in_beat_t   in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output stok_pkg::out_beat_t  out_data
);
	import stok_pkg::*;

	logic v_s1;
	in_beat_t d_s1;
	logic step, empty_next;
	res_group_t grp;

	// stage one advances into the scanner when the result register frees up
	assign step = v_s1 && empty_next;
	assign in_ready = !v_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (in_ready) v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) d_s1 <= in_data;
	end

	stok_scan u_scan (
		.clk(clk), .arst_n(arst_n), .step(step), .beat(d_s1), .grp(grp)
	);

	stok_out_buf u_out (
		.clk(clk), .arst_n(arst_n), .load(step), .grp(grp),
		.empty_next(empty_next), .out_valid(out_valid), .out_data(out_data),
		.out_ready(out_ready)
	);

	`ST_ASSERT_IMP(a_step_ready, clk, arst_n, step, in_ready)
	`ST_ASSERT_IMP(a_no_step_idle, clk, arst_n, !v_s1, !step)
	`ST_ASSERT_NXT(a_hold_out, clk, arst_n, out_valid && !out_ready, out_valid)
endmodule
